>>> src/pctt_pkg.sv
`timescale 1ns / 1ps

package pctt_pkg;

   localparam int TABLE_DEPTH = 16;
   localparam int IDX_W       = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int WORD_W      = 32;
   localparam int ACT_W       = 3;
   localparam int STAT_W      = 2;

   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;
   localparam logic [CSR_ADDR_W-3:0] REG_AGE_LIMIT = '0;

   localparam logic [ACT_W-1:0] ACT_ADD     = 3'd0;
   localparam logic [ACT_W-1:0] ACT_FREE    = 3'd1;
   localparam logic [ACT_W-1:0] ACT_FIND    = 3'd2;
   localparam logic [ACT_W-1:0] ACT_EXPIRED = 3'd3;
   localparam logic [ACT_W-1:0] ACT_TICK    = 3'd4;

   localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
   localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [STAT_W-1:0] ST_INVALID   = 2'd2;
   localparam logic [STAT_W-1:0] ST_FULL      = 2'd3;

   // what a caller sees of one entry
   typedef struct packed {
      logic [WORD_W-1:0] cmd;
      logic [WORD_W-1:0] flags;
      logic [WORD_W-1:0] contact;
      logic [WORD_W-1:0] ack_type;
      logic [WORD_W-1:0] data_ref;
      logic [WORD_W-1:0] data_size;
   } rpt_type;

   // one stored table row
   typedef struct packed {
      rpt_type           rpt;
      logic [WORD_W-1:0] stamp;
   } entry_type;

   typedef struct packed {
      logic              load_req;
      logic              do_add;
      logic              do_tick;
      logic              scan_init;
      logic              scan_run;
      logic              shift_init;
      logic              shift_run;
      logic              dec_cnt;
      logic              res_load;
      logic [STAT_W-1:0] res_status;
      logic              res_entry;
      logic              out_push;
   } dp_cmd_type;

   typedef struct packed {
      logic [ACT_W-1:0] act;
      logic             num_zero;
      logic             full;
      logic             empty;
      logic             rdv;
      logic             hit;
      logic             last;
      logic             out_free;
   } dp_sts_type;

endpackage

>>> src/pctt_req_if.sv
`timescale 1ns / 1ps

interface pctt_req_if;
   import pctt_pkg::*;

   logic              valid;
   logic              ready;
   logic [ACT_W-1:0]  action;
   logic [WORD_W-1:0] cmd_num;
   logic [WORD_W-1:0] flags_in;
   logic [WORD_W-1:0] contact_in;
   logic [WORD_W-1:0] ack_type_in;
   logic [WORD_W-1:0] data_ref_in;
   logic [WORD_W-1:0] data_size_in;

   modport source (
      output valid, action, cmd_num, flags_in, contact_in, ack_type_in,
             data_ref_in, data_size_in,
      input  ready
   );

   modport sink (
      input  valid, action, cmd_num, flags_in, contact_in, ack_type_in,
             data_ref_in, data_size_in,
      output ready
   );
endinterface

>>> src/pctt_rsp_if.sv
`timescale 1ns / 1ps

interface pctt_rsp_if;
   import pctt_pkg::*;

   logic              valid;
   logic              ready;
   logic [STAT_W-1:0] status;
   logic [WORD_W-1:0] cmd_num_out;
   logic [WORD_W-1:0] flags_out;
   logic [WORD_W-1:0] contact_out;
   logic [WORD_W-1:0] ack_type_out;
   logic [WORD_W-1:0] data_ref_out;
   logic [WORD_W-1:0] data_size_out;

   modport source (
      output valid, status, cmd_num_out, flags_out, contact_out, ack_type_out,
             data_ref_out, data_size_out,
      input  ready
   );

   modport sink (
      input  valid, status, cmd_num_out, flags_out, contact_out, ack_type_out,
             data_ref_out, data_size_out,
      output ready
   );
endinterface

>>> src/pctt_ctrl.sv
`timescale 1ns / 1ps

module pctt_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  pctt_pkg::dp_sts_type sts,
   output pctt_pkg::dp_cmd_type cmd
);
   import pctt_pkg::*;

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_EXEC  = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_SHIFT = 3'd3;
   localparam logic [2:0] S_DONE  = 3'd4;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               state_in     = S_EXEC;
            end
         end
         S_EXEC: begin
            state_in       = S_DONE;
            cmd.res_load   = 1'b1;
            cmd.res_status = ST_OK;
            unique case (sts.act) inside
               ACT_ADD: begin
                  if (sts.num_zero) begin
                     cmd.res_status = ST_INVALID;
                  end else if (sts.full) begin
                     cmd.res_status = ST_FULL;
                  end else begin
                     cmd.do_add = 1'b1;
                  end
               end
               ACT_FREE, ACT_FIND, ACT_EXPIRED: begin
                  if (sts.empty) begin
                     cmd.res_status = ST_NOT_FOUND;
                  end else begin
                     cmd.res_load  = 1'b0;
                     cmd.scan_init = 1'b1;
                     state_in      = S_SCAN;
                  end
               end
               ACT_TICK: begin
                  cmd.do_tick = 1'b1;
               end
               default: ;
            endcase
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.rdv && sts.hit) begin
               if (sts.act == ACT_FREE) begin
                  if (sts.last) begin
                     // hit on the tail entry: nothing to move up
                     cmd.dec_cnt    = 1'b1;
                     cmd.res_load   = 1'b1;
                     cmd.res_status = ST_OK;
                     state_in       = S_DONE;
                  end else begin
                     cmd.scan_run   = 1'b0;
                     cmd.shift_init = 1'b1;
                     state_in       = S_SHIFT;
                  end
               end else begin
                  cmd.res_load   = 1'b1;
                  cmd.res_status = ST_OK;
                  cmd.res_entry  = 1'b1;
                  state_in       = S_DONE;
               end
            end else if (sts.rdv && sts.last) begin
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_NOT_FOUND;
               state_in       = S_DONE;
            end
         end
         S_SHIFT: begin
            cmd.shift_run = 1'b1;
            if (sts.rdv && sts.last) begin
               cmd.dec_cnt    = 1'b1;
               cmd.res_load   = 1'b1;
               cmd.res_status = ST_OK;
               state_in       = S_DONE;
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.out_push = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   a_shift_only_free: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SHIFT) |-> (sts.act == ACT_FREE))
      else $error("compaction running for an action other than free");

endmodule

>>> src/pctt_dp.sv
`timescale 1ns / 1ps

module pctt_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  pctt_pkg::dp_cmd_type             cmd,
   output pctt_pkg::dp_sts_type             sts,
   input  logic [pctt_pkg::ACT_W-1:0]       req_action,
   input  pctt_pkg::rpt_type                req_ent,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [pctt_pkg::STAT_W-1:0]      rsp_status,
   output pctt_pkg::rpt_type                rsp_ent,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pctt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pctt_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pctt_pkg::CSR_DATA_W-1:0]  csr_prdata
);
   import pctt_pkg::*;

   entry_type entry_mem [TABLE_DEPTH];

   logic [ACT_W-1:0]  act_ff;
   rpt_type           add_ff;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [WORD_W-1:0] time_ff, time_in;
   logic [WORD_W-1:0] limit_ff, limit_in;
   logic [CNT_W-1:0]  ptr_ff, ptr_in;
   logic [IDX_W-1:0]  chk_ff, chk_in;
   logic              rdv_ff, rdv_in;
   logic              rd_en;
   entry_type         rd_data_ff;
   logic [STAT_W-1:0] res_status_ff;
   rpt_type           res_ent_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff;
   rpt_type           rsp_ent_ff;
   logic [WORD_W-1:0] age;
   logic              csr_sel;
   logic              csr_wr;
   logic              run;

   assign csr_sel    = (csr_paddr[CSR_ADDR_W-1:2] == REG_AGE_LIMIT);
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_sel;
   assign csr_prdata = csr_sel ? limit_ff : '0;
   assign limit_in   = csr_wr ? csr_pwdata : limit_ff;

   assign age = time_ff - rd_data_ff.stamp;
   assign run = cmd.scan_run || cmd.shift_run;

   always_comb begin
      sts          = '0;
      sts.act      = act_ff;
      sts.num_zero = (add_ff.cmd == '0);
      sts.full     = (cnt_ff == CNT_W'(TABLE_DEPTH));
      sts.empty    = (cnt_ff == '0);
      sts.rdv      = rdv_ff;
      sts.last     = (CNT_W'(chk_ff) == cnt_ff - CNT_W'(1));
      sts.out_free = !rsp_valid_ff || rsp_ready;
      if (act_ff == ACT_EXPIRED) begin
         sts.hit = (age > limit_ff);
      end else begin
         sts.hit = (rd_data_ff.rpt.cmd == add_ff.cmd);
      end
   end

   // scan pointer: one table read per cycle, checked in the following cycle
   always_comb begin
      ptr_in = ptr_ff;
      chk_in = chk_ff;
      rdv_in = rdv_ff;
      rd_en  = 1'b0;
      if (cmd.scan_init) begin
         ptr_in = '0;
         rdv_in = 1'b0;
      end else if (cmd.shift_init) begin
         ptr_in = CNT_W'(chk_ff) + CNT_W'(1);
         rdv_in = 1'b0;
      end else if (run) begin
         if (ptr_ff < cnt_ff) begin
            rd_en  = 1'b1;
            chk_in = ptr_ff[IDX_W-1:0];
            ptr_in = ptr_ff + CNT_W'(1);
            rdv_in = 1'b1;
         end else begin
            rdv_in = 1'b0;
         end
      end
   end

   always_comb begin
      cnt_in = cnt_ff;
      if (cmd.do_add) begin
         cnt_in = cnt_ff + CNT_W'(1);
      end else if (cmd.dec_cnt) begin
         cnt_in = cnt_ff - CNT_W'(1);
      end
   end

   assign time_in      = cmd.do_tick ? time_ff + WORD_W'(1) : time_ff;
   assign rsp_valid_in = cmd.out_push ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         time_ff      <= '0;
         limit_ff     <= '0;
         rdv_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         time_ff      <= time_in;
         limit_ff     <= limit_in;
         rdv_ff       <= rdv_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ptr_ff <= ptr_in;
      chk_ff <= chk_in;
      if (cmd.load_req) begin
         act_ff <= req_action;
         add_ff <= req_ent;
      end
      if (cmd.res_load) begin
         res_status_ff <= cmd.res_status;
         res_ent_ff    <= cmd.res_entry ? rd_data_ff.rpt : '0;
      end
      if (cmd.out_push) begin
         rsp_status_ff <= res_status_ff;
         rsp_ent_ff    <= res_ent_ff;
      end
   end

   // table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.do_add) begin
         entry_mem[cnt_ff[IDX_W-1:0]] <= '{rpt: add_ff, stamp: time_ff};
      end else if (cmd.shift_run && rdv_ff) begin
         entry_mem[chk_ff - IDX_W'(1)] <= rd_data_ff;
      end
      if (rd_en) begin
         rd_data_ff <= entry_mem[ptr_ff[IDX_W-1:0]];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_ent    = rsp_ent_ff;

   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(TABLE_DEPTH))
      else $error("entry count above table depth");

   a_cnt_step: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == $past(cnt_ff)) || (cnt_ff == $past(cnt_ff) + CNT_W'(1)) ||
      (cnt_ff == $past(cnt_ff) - CNT_W'(1)))
      else $error("entry count moved by more than one");

   a_time_tick: assert property (@(posedge clock) disable iff (reset)
      (time_ff != $past(time_ff)) |-> $past(cmd.do_tick))
      else $error("time counter moved without a tick");

endmodule

>>> src/pending_command_table_with_timeout.sv
`timescale 1ns / 1ps

// Ordered table of up to 16 outstanding commands with tick-based expiry.
// Items are taken one at a time. Add, tick and unused actions go from the
// execute state to the done state, which loads the output register. Find and
// find-expired walk the table through its single registered read port, one
// entry per cycle, and answer on a hit or after the last entry. Free runs the
// same walk and then moves each later entry up one slot, again one per cycle.
// The next request is accepted as soon as the previous result sits in the output
// register, even if that beat has not yet been taken. age_limit sits at byte
// address 0 of the csr port and should only be written while the block is idle.

module pending_command_table_with_timeout (
   input  logic                             clock,
   input  logic                             reset,
   pctt_req_if.sink                         req_ch,
   pctt_rsp_if.source                       rsp_ch,
   input  logic                             csr_psel,
   input  logic                             csr_penable,
   input  logic                             csr_pwrite,
   input  logic [pctt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [pctt_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output logic [pctt_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output logic                             csr_pready
);
   import pctt_pkg::*;

   dp_cmd_type cmd;
   dp_sts_type sts;
   rpt_type    req_ent;
   rpt_type    rsp_ent;

   assign csr_pready = 1'b1;

   assign req_ent = '{cmd:       req_ch.cmd_num,
                      flags:     req_ch.flags_in,
                      contact:   req_ch.contact_in,
                      ack_type:  req_ch.ack_type_in,
                      data_ref:  req_ch.data_ref_in,
                      data_size: req_ch.data_size_in};

   assign rsp_ch.cmd_num_out   = rsp_ent.cmd;
   assign rsp_ch.flags_out     = rsp_ent.flags;
   assign rsp_ch.contact_out   = rsp_ent.contact;
   assign rsp_ch.ack_type_out  = rsp_ent.ack_type;
   assign rsp_ch.data_ref_out  = rsp_ent.data_ref;
   assign rsp_ch.data_size_out = rsp_ent.data_size;

   pctt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   pctt_dp u_dp (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .sts         (sts),
      .req_action  (req_ch.action),
      .req_ent     (req_ent),
      .rsp_valid   (rsp_ch.valid),
      .rsp_ready   (rsp_ch.ready),
      .rsp_status  (rsp_ch.status),
      .rsp_ent     (rsp_ent),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata)
   );

endmodule

>>> dv/tb.sv
`timescale 1ns / 1ps

module tb;
   import pctt_pkg::*;

   // action codes the block treats as no-ops
   localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
   localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;
   // csr index that decodes to nothing
   localparam logic [CSR_ADDR_W-3:0] REG_UNUSED = 1'b1;
   localparam logic [WORD_W-1:0] ALL_ONES = '1;
   localparam int STALL_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 30;

   typedef struct packed {
      logic [ACT_W-1:0] action;
      rpt_type          body;   // body.cmd carries cmd_num
   } op_type;

   typedef struct packed {
      logic [STAT_W-1:0] status;
      rpt_type           rpt;
   } answer_type;

   logic clock;
   logic reset;

   pctt_req_if req_bus();
   pctt_rsp_if rsp_bus();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   pending_command_table_with_timeout i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_bus),
      .rsp_ch      (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   // table model
   entry_type         shadow_tbl [TABLE_DEPTH];
   int                shadow_count;
   logic [WORD_W-1:0] shadow_time;
   logic [WORD_W-1:0] shadow_age_limit;

   answer_type due_answers[$];
   int      errors;
   int      beats_sent;
   int      beats_checked;
   int      full_seen;
   int      expired_seen;
   int      idle_cycles;
   bit      calm;

   always begin
      clock = 1'b1;
      #4;
      clock = 1'b0;
      #4;
   end

   function automatic int locate_cmd(logic [WORD_W-1:0] num);
      int hit;
      hit = -1;
      for (int i = 0; i < shadow_count; i++) begin
         if (hit < 0 && shadow_tbl[i].rpt.cmd == num) begin
            hit = i;
         end
      end
      return hit;
   endfunction

   // applies one operation to the model and returns the answer it owes
   function automatic answer_type model_table_op(op_type op);
      answer_type        ans;
      int                hit;
      logic [WORD_W-1:0] age;
      ans = '0;
      ans.status = ST_OK;
      case (op.action)
         ACT_ADD: begin
            if (op.body.cmd == '0) begin
               ans.status = ST_INVALID;
            end else if (shadow_count >= TABLE_DEPTH) begin
               ans.status = ST_FULL;
               full_seen++;
            end else begin
               shadow_tbl[shadow_count].rpt = op.body;
               shadow_tbl[shadow_count].stamp = shadow_time;
               shadow_count++;
            end
         end
         ACT_FREE: begin
            hit = locate_cmd(op.body.cmd);
            if (hit < 0) begin
               ans.status = ST_NOT_FOUND;
            end else begin
               for (int i = hit; i + 1 < shadow_count; i++) begin
                  shadow_tbl[i] = shadow_tbl[i + 1];
               end
               shadow_count--;
            end
         end
         ACT_FIND: begin
            hit = locate_cmd(op.body.cmd);
            if (hit < 0) begin
               ans.status = ST_NOT_FOUND;
            end else begin
               ans.rpt = shadow_tbl[hit].rpt;
            end
         end
         ACT_EXPIRED: begin
            hit = -1;
            for (int i = 0; i < shadow_count; i++) begin
               age = shadow_time - shadow_tbl[i].stamp;
               if (hit < 0 && age > shadow_age_limit) begin
                  hit = i;
               end
            end
            if (hit < 0) begin
               ans.status = ST_NOT_FOUND;
            end else begin
               ans.rpt = shadow_tbl[hit].rpt;
               expired_seen++;
            end
         end
         ACT_TICK: begin
            shadow_time = shadow_time + 1'b1;
         end
         default: begin
         end
      endcase
      return ans;
   endfunction

   // one request beat; called and returning at a rising edge
   task automatic send_op(logic [ACT_W-1:0] action, logic [WORD_W-1:0] num,
                          rpt_type body);
      op_type op;
      int     gap;
      op.action = action;
      op.body = body;
      op.body.cmd = num;
      gap = calm ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.action <= op.action;
      req_bus.cmd_num <= op.body.cmd;
      req_bus.flags_in <= op.body.flags;
      req_bus.contact_in <= op.body.contact;
      req_bus.ack_type_in <= op.body.ack_type;
      req_bus.data_ref_in <= op.body.data_ref;
      req_bus.data_size_in <= op.body.data_size;
      do @(posedge clock); while (!req_bus.ready);
      due_answers.push_back(model_table_op(op));
      beats_sent++;
   endtask

   function automatic rpt_type random_body();
      rpt_type b;
      b.cmd = $urandom();
      b.flags = $urandom();
      b.contact = $urandom();
      b.ack_type = $urandom();
      b.data_ref = $urandom();
      b.data_size = $urandom();
      return b;
   endfunction

   // mostly a small pool so that finds and frees hit
   function automatic logic [WORD_W-1:0] pick_cmd();
      int roll;
      roll = $urandom_range(0, 99);
      if (roll < 5) return '0;
      if (roll < 15) return $urandom();
      return $urandom_range(1, 10);
   endfunction

   task automatic settle();
      req_bus.valid <= 1'b0;
      while (due_answers.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_ADDR_W-3:0] index, logic [CSR_DATA_W-1:0] value);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= {index, 2'b00};
      csr_pwdata <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (index == REG_AGE_LIMIT) begin
         shadow_age_limit = value;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(posedge clock);
   endtask

   task automatic csr_check_limit();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= {REG_AGE_LIMIT, 2'b00};
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== shadow_age_limit) begin
         $error("age_limit: expected %h, got %h", shadow_age_limit, csr_prdata);
         errors++;
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_age_limit(logic [WORD_W-1:0] value);
      settle();
      csr_write(REG_AGE_LIMIT, value);
      csr_check_limit();
   endtask

   // zero numbers, empty table, spare codes, field extremes, duplicates
   task automatic test_special_cases();
      rpt_type ones;
      rpt_type zeros;
      ones = '1;
      zeros = '0;
      calm = 1'b1;
      set_age_limit('0);
      send_op(ACT_ADD, '0, random_body());
      send_op(ACT_FIND, '0, zeros);
      send_op(ACT_FREE, '0, zeros);
      send_op(ACT_EXPIRED, '0, zeros);
      send_op(ACT_TICK, ALL_ONES, ones);
      for (int a = ACT_SPARE_LO; a <= ACT_SPARE_HI; a++) begin
         send_op(a[ACT_W-1:0], ALL_ONES, ones);
      end
      send_op(ACT_FREE, 32'd5, zeros);
      send_op(ACT_ADD, ALL_ONES, ones);
      send_op(ACT_ADD, 32'd1, zeros);
      send_op(ACT_ADD, 32'h5555_5555, random_body());
      send_op(ACT_FIND, ALL_ONES, zeros);
      send_op(ACT_FIND, 32'd1, ones);
      send_op(ACT_FIND, '0, zeros);
      calm = 1'b0;
      send_op(ACT_ADD, 32'd1, random_body());
      send_op(ACT_FIND, 32'd1, zeros);
      send_op(ACT_FREE, 32'd1, zeros);
      send_op(ACT_FIND, 32'd1, zeros);
      // nothing has aged yet at a limit of zero
      send_op(ACT_EXPIRED, '0, zeros);
      send_op(ACT_TICK, '0, zeros);
      send_op(ACT_EXPIRED, '0, zeros);
      send_op(ACT_FREE, ALL_ONES, zeros);
      send_op(ACT_FREE, 32'h5555_5555, zeros);
      send_op(ACT_FREE, 32'd1, zeros);
      send_op(ACT_FIND, 32'd1, zeros);
   endtask

   // fill to the brim, overflow, then drain in random order
   task automatic test_full_table();
      logic [WORD_W-1:0] nums[$];
      logic [WORD_W-1:0] num;
      int                k;
      set_age_limit(ALL_ONES);
      for (int i = 0; i < TABLE_DEPTH + 3; i++) begin
         num = $urandom_range(1, 4) == 1 ? $urandom() | 32'h1 : i + 100;
         nums.push_back(num);
         send_op(ACT_ADD, num, random_body());
         if (i % 4 == 3) send_op(ACT_TICK, $urandom(), random_body());
      end
      send_op(ACT_EXPIRED, $urandom(), random_body());
      send_op(ACT_FIND, nums[TABLE_DEPTH - 1], random_body());
      while (nums.size() != 0) begin
         k = $urandom_range(0, nums.size() - 1);
         send_op(ACT_FREE, nums[k], random_body());
         if ($urandom_range(0, 2) == 0) send_op(ACT_FIND, nums[k], random_body());
         nums.delete(k);
      end
   endtask

   task automatic test_mixed_traffic(int count, int add_pct);
      int               roll;
      logic [ACT_W-1:0] act;
      for (int n = 0; n < count; n++) begin
         if (n % 32 == 0) calm = $urandom_range(0, 3) == 0;
         roll = $urandom_range(0, 99);
         if (roll < add_pct) begin
            act = ACT_ADD;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 28) act = ACT_FREE;
            else if (roll < 52) act = ACT_FIND;
            else if (roll < 74) act = ACT_EXPIRED;
            else if (roll < 97) act = ACT_TICK;
            else act = ACT_W'($urandom_range(ACT_SPARE_LO, ACT_SPARE_HI));
         end
         send_op(act, pick_cmd(), random_body());
      end
      calm = 1'b0;
   endtask

   // drives ready for the result channel
   initial begin
      int stall;
      forever begin
         stall = calm ? 0 : $urandom_range(0, 3);
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         do @(posedge clock); while (!rsp_bus.valid);
      end
   end

   task automatic check_field(string name, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
      if (got !== want) begin
         $error("%s: expected %h, got %h", name, want, got);
         errors++;
      end
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (due_answers.size() == 0) begin
            $error("result beat with nothing outstanding");
            errors++;
         end else begin
            want = due_answers.pop_front();
            beats_checked++;
            check_field("status", WORD_W'(want.status), WORD_W'(rsp_bus.status));
            check_field("cmd_num_out", want.rpt.cmd, rsp_bus.cmd_num_out);
            check_field("flags_out", want.rpt.flags, rsp_bus.flags_out);
            check_field("contact_out", want.rpt.contact, rsp_bus.contact_out);
            check_field("ack_type_out", want.rpt.ack_type, rsp_bus.ack_type_out);
            check_field("data_ref_out", want.rpt.data_ref, rsp_bus.data_ref_out);
            check_field("data_size_out", want.rpt.data_size, rsp_bus.data_size_out);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)
          || (csr_psel && csr_penable)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles == STALL_LIMIT) begin
         $display("tb: done, errors");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid <= 1'b0;
      req_bus.action <= ACT_TICK;
      req_bus.cmd_num <= '0;
      req_bus.flags_in <= '0;
      req_bus.contact_in <= '0;
      req_bus.ack_type_in <= '0;
      req_bus.data_ref_in <= '0;
      req_bus.data_size_in <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      shadow_count = 0;
      shadow_time = '0;
      shadow_age_limit = '0;
      errors = 0;
      beats_sent = 0;
      beats_checked = 0;
      full_seen = 0;
      expired_seen = 0;
      idle_cycles = 0;
      calm = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_special_cases();
      test_full_table();
      set_age_limit('0);
      test_mixed_traffic(160, 35);
      set_age_limit(32'd2);
      test_mixed_traffic(160, 50);
      set_age_limit($urandom_range(0, 8));
      test_mixed_traffic(150, 25);
      settle();
      // write to an undecoded index must leave age_limit alone
      csr_write(REG_UNUSED, $urandom());
      csr_check_limit();
      set_age_limit(32'h8000_0000 | $urandom());
      test_mixed_traffic(60, 40);
      set_age_limit(ALL_ONES);
      test_mixed_traffic(40, 40);

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("tb: %0d requests sent, %0d results checked", beats_sent, beats_checked);
      $display("tb: %0d table-full rejects, %0d expired hits, final tick count %0d",
               full_seen, expired_seen, shadow_time);
      if (errors == 0 && due_answers.size() == 0) begin
         $display("tb: done, clean");
      end else begin
         $display("tb: done, errors");
      end
      $finish;
   end

endmodule
